// ===== rtl/b64d_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream decoder
package b64d_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam int unsigned MAX_RES  = 3;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       is_last;
    logic       error;
  } res_t;

  // results caused by one input item
  typedef struct packed {
    logic [1:0]       count;
    res_t [MAX_RES-1:0] item;
  } res_group_t;

  // alphabet lookup on the low 7 bits; bad is set for characters outside the table
  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [6:0] c);
    sextet_t s;
    logic [6:0] v;
    s.bad = 1'b0;
    v     = 7'd0;
    case (c) inside
      [7'h41:7'h5A]: v = c - 7'h41;
      [7'h61:7'h7A]: v = c - 7'h47;
      [7'h30:7'h39]: v = c + 7'h04;
      7'h2B, 7'h2D:  v = 7'd62;
      7'h2F, 7'h5F:  v = 7'd63;
      7'h3D:         v = 7'd0;
      default:       s.bad = 1'b1;
    endcase
    s.val = v[5:0];
    return s;
  endfunction

endpackage

// ===== rtl/b64d_decode.sv =====
// group state and per-item decode: turns one accepted character into up to three results
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_char,
  input  logic       in_end_of_input,
  output res_group_t group
);

  logic [17:0] store_r, store_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        third_r, third_nxt;
  logic        failed_r, failed_nxt;

  logic        is_crlf, pad, bad, failed_cur;
  logic [5:0]  val;
  logic [23:0] grp;
  logic [1:0]  cnt;
  sextet_t     lk;

  always_comb begin
    group       = '0;
    store_nxt   = store_r;
    pos_nxt     = pos_r;
    third_nxt   = third_r;
    failed_nxt  = failed_r;

    is_crlf    = (in_char == CHAR_CR) || (in_char == CHAR_LF);
    pad        = (in_char == CHAR_EQ) || (in_char == CHAR_DOT);
    lk         = sextet_of(in_char[6:0]);
    bad        = !pad && lk.bad;
    val        = (pad || lk.bad) ? 6'd0 : lk.val;
    failed_cur = failed_r | bad;
    grp        = {store_r, val};
    cnt        = 2'd3;

    if (is_crlf) begin
      if (in_end_of_input) begin
        group.count   = 2'd1;
        group.item[0] = '{data: 8'd0, byte_valid: 1'b0, is_last: 1'b1,
                          error: failed_r | (pos_r != 2'd0)};
        store_nxt  = '0;
        pos_nxt    = '0;
        third_nxt  = 1'b0;
        failed_nxt = 1'b0;
      end
    end else if (pos_r != 2'd3) begin
      failed_nxt = failed_cur;
      if (pos_r == 2'd2) begin
        third_nxt = pad;
      end
      store_nxt = {store_r[11:0], val};
      pos_nxt   = pos_r + 2'd1;
      if (in_end_of_input) begin
        // incomplete final group: drop partial bytes, flag it
        group.count   = 2'd1;
        group.item[0] = '{data: 8'd0, byte_valid: 1'b0, is_last: 1'b1, error: 1'b1};
        store_nxt  = '0;
        pos_nxt    = '0;
        third_nxt  = 1'b0;
        failed_nxt = 1'b0;
      end
    end else begin
      if (in_end_of_input) begin
        cnt = 2'd3 - {1'b0, third_r} - {1'b0, pad};
      end
      group.count   = cnt;
      group.item[0] = '{data: grp[23:16], byte_valid: 1'b1,
                        is_last: in_end_of_input && (cnt == 2'd1), error: failed_cur};
      group.item[1] = '{data: grp[15:8], byte_valid: 1'b1,
                        is_last: in_end_of_input && (cnt == 2'd2), error: failed_cur};
      group.item[2] = '{data: grp[7:0], byte_valid: 1'b1,
                        is_last: in_end_of_input && (cnt == 2'd3), error: failed_cur};
      store_nxt  = '0;
      pos_nxt    = '0;
      third_nxt  = 1'b0;
      failed_nxt = in_end_of_input ? 1'b0 : failed_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r  <= '0;
      pos_r    <= '0;
      third_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (accept) begin
      store_r  <= store_nxt;
      pos_r    <= pos_nxt;
      third_r  <= third_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== rtl/b64d_fifo.sv =====
// result queue: takes up to three results per cycle, hands out one per cycle while rd_ready is high
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  res_group_t wr_group,
  output logic       has_room,
  output logic       rd_valid,
  input  logic       rd_ready,
  output res_t       rd_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] idx [MAX_RES];
  logic [PW:0]   sum [MAX_RES+1];
  logic [1:0]    wr_n;
  logic          rd;

  assign has_room = count_r <= CW'(DEPTH - MAX_RES);
  assign rd_valid = count_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign rd       = rd_valid && rd_ready;
  assign wr_n     = wr_en ? wr_group.count : 2'd0;

  always_comb begin
    for (int k = 0; k <= MAX_RES; k++) begin
      sum[k] = {1'b0, wr_ptr_r} + (PW+1)'(k);
      if (sum[k] >= (PW+1)'(DEPTH)) begin
        sum[k] = sum[k] - (PW+1)'(DEPTH);
      end
    end
    for (int k = 0; k < MAX_RES; k++) begin
      idx[k] = sum[k][PW-1:0];
    end
    wr_ptr_nxt = sum[wr_n][PW-1:0];
    rd_ptr_nxt = rd_ptr_r;
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(wr_n) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(wr_n)) begin
        mem_r[idx[k]] <= wr_group.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// top level of the base64 stream decoder: decode stage feeding a result queue
//
// base64 stream decoder. one encoded character is taken per item and one result
// is delivered per cycle while out_ready is high. CR and LF are skipped; the
// standard alphabet plus '-' and '_' is accepted; every fourth character
// completes a group and pushes three bytes. in the final group, '=' or '.' in
// the third and fourth place each drop one byte. an invalid character or a
// stream ending mid-group sets error on the results of that stream (the consumer
// should discard it). the end item always yields one result with is_last set; a
// marker result has byte_valid low. rate: a new item every cycle while the
// result queue has room for three more results (count <= DEPTH-3); results drain
// one per cycle while out_ready is high, so the link keeps pace at the usual 4
// characters in / 3 bytes out.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int DEPTH = 8   // result queue depth, at least 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_input,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_is_last,
  output logic       out_error
);

  logic       accept;
  res_group_t group;
  res_t       head;

  // an item is taken only when all its possible results fit in the queue
  assign accept = in_valid && in_ready;

  // decode stage: group state plus lookup, produces 0..3 results
  b64d_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_char         (in_char),
    .in_end_of_input (in_end_of_input),
    .group           (group)
  );

  // result queue parts the two sides so input keeps flowing during output stalls
  b64d_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_group (group),
    .has_room (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_item  (head)
  );

  // result fields from the queue head
  assign out_byte       = head.data;
  assign out_byte_valid = head.byte_valid;
  assign out_is_last    = head.is_last;
  assign out_error      = head.error;

endmodule

// ===== tb/tb_base64_stream_decoder.sv =====
// self-checking testbench for the base64 stream decoder
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
  import b64d_pkg::*;

  // cycles with no accepted item on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 1000;
  // long receiver hold-off that lets the result queue fill and stall the input
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int HOLD_OFF_AFTER = 80;
  // total accepted items (ignored line breaks excluded), last stretch without idling
  localparam int ITEM_TOTAL = 250;
  localparam int DRAIN_FROM = 200;

  // hand-typed results for rows that are obvious at a glance
  localparam res_t NO_RESULT    = '0;
  localparam res_t MARK_OK      = {8'h00, 1'b0, 1'b1, 1'b0};
  localparam res_t MARK_ERR     = {8'h00, 1'b0, 1'b1, 1'b1};
  localparam res_t BYTE_FF      = {8'hFF, 1'b1, 1'b0, 1'b0};
  localparam res_t BYTE_FF_LAST = {8'hFF, 1'b1, 1'b1, 1'b0};

  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    bit          typed;
    int          n;
    res_t [2:0]  res;     // res[0] comes out first
  } char_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_is_last;
  logic       out_error;

  // annotation that travels with the item on in_*
  bit         cur_typed;
  int         cur_n;
  res_t [2:0] cur_res;

  char_row_t  stim_rows[$];
  res_t       due_results[$];
  int         errors;
  int         sent_items;
  int         accepted_items;
  int         quiet_cycles;
  bit         drain_phase;

  // decoder state as predicted
  logic [17:0] held_sextets;
  logic [1:0]  group_pos;
  logic        third_pad;
  logic        stream_failed;

  base64_stream_decoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_is_last     (out_is_last),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // alphabet lookup: bit 6 set means the character is not in the alphabet
  function automatic logic [6:0] sextet_lookup(input logic [6:0] c);
    logic [6:0] d;
    if (c >= 7'h41 && c <= 7'h5A) d = c - 7'h41;         // upper case
    else if (c >= 7'h61 && c <= 7'h7A) d = c - 7'h47;    // lower case
    else if (c >= 7'h30 && c <= 7'h39) d = c + 7'h04;    // digits
    else if (c == 7'h2B || c == 7'h2D) d = 7'd62;        // plus or minus
    else if (c == 7'h2F || c == 7'h5F) d = 7'd63;        // slash or underscore
    else if (c == 7'h3D) d = 7'd0;                       // equals sign in the table
    else d = 7'h40;
    return d;
  endfunction

  task automatic clear_stream();
    held_sextets  = '0;
    group_pos     = '0;
    third_pad     = 1'b0;
    stream_failed = 1'b0;
  endtask

  // predicts the results of one accepted character and advances the state
  task automatic decode_char(input logic [7:0] ch, input logic eoi,
                             output int n, output res_t [2:0] r);
    logic [6:0]  look;
    logic [5:0]  val;
    logic [23:0] group;
    logic        pad;
    int          cnt;
    n = 0;
    r = '0;
    if (ch == CHAR_CR || ch == CHAR_LF) begin
      // line breaks are skipped unless they close the stream
      if (eoi) begin
        n = 1;
        r[0] = {8'h00, 1'b0, 1'b1, stream_failed | (group_pos != 2'd0)};
        clear_stream();
      end
      return;
    end
    pad = (ch == CHAR_EQ || ch == CHAR_DOT);
    look = sextet_lookup(ch[6:0]);
    val = pad ? 6'd0 : look[5:0];
    if (!pad && look[6]) begin
      // bad character counts as zero and taints the stream
      stream_failed = 1'b1;
      val = 6'd0;
    end
    if (group_pos != 2'd3) begin
      if (group_pos == 2'd2) third_pad = pad;
      held_sextets = {held_sextets[11:0], val};
      group_pos = group_pos + 2'd1;
      if (eoi) begin
        // stream ends mid-group: partial bytes dropped
        n = 1;
        r[0] = MARK_ERR;
        clear_stream();
      end
      return;
    end
    group = {held_sextets, val};
    cnt = eoi ? 3 - int'(third_pad) - int'(pad) : 3;
    for (int i = 0; i < cnt; i++)
      r[i] = {group[23-8*i -: 8], 1'b1, eoi && (i == cnt - 1), stream_failed};
    n = cnt;
    held_sextets = '0;
    group_pos = '0;
    third_pad = 1'b0;
    if (eoi) clear_stream();
  endtask

  task automatic field_check(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // scoreboard and watchdog counter, sampled on the rising edge
  always @(posedge clk) begin : scoreboard
    int         n;
    res_t [2:0] r;
    res_t       want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_char(in_char, in_end_of_input, n, r);
        if (cur_typed) begin
          n = cur_n;
          r = cur_res;
        end
        for (int i = 0; i < n; i++) due_results.push_back(r[i]);
        accepted_items++;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0h valid %0b last %0b err %0b",
                   $time, out_byte, out_byte_valid, out_is_last, out_error);
          errors++;
        end else begin
          want = due_results.pop_front();
          field_check("out_byte", want.data, out_byte);
          field_check("out_byte_valid", {7'd0, want.byte_valid}, {7'd0, out_byte_valid});
          field_check("out_is_last", {7'd0, want.is_last}, {7'd0, out_is_last});
          field_check("out_error", {7'd0, want.error}, {7'd0, out_error});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("** base64_stream_decoder: FAILED **");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off, none while draining
  initial begin : receiver
    int stall;
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && accepted_items >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!drain_phase && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one item, optionally after an idle burst, and wait for its handshake
  task automatic send(input logic [7:0] ch, input logic eoi, input bit typed,
                      input int n, input res_t [2:0] res);
    int gap;
    if (!drain_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char         <= ch;
    in_end_of_input <= eoi;
    cur_typed       <= typed;
    cur_n           <= n;
    cur_res         <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // skipped line breaks do not count toward the run length
    if (eoi || (ch != CHAR_CR && ch != CHAR_LF)) sent_items++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eoi, input bit typed,
                         input int n, input res_t [2:0] res);
    char_row_t row;
    row.ch = ch;
    row.eoi = eoi;
    row.typed = typed;
    row.n = n;
    row.res = res;
    stim_rows.push_back(row);
  endtask

  function automatic logic [7:0] valid_char();
    int v;
    v = $urandom_range(0, 65);
    if (v < 26) return 8'h41 + v[7:0];
    if (v < 52) return 8'h61 + v[7:0] - 8'd26;
    if (v < 62) return 8'h30 + v[7:0] - 8'd52;
    if (v == 62) return "+";
    if (v == 63) return "/";
    if (v == 64) return "-";
    return "_";
  endfunction

  function automatic logic [7:0] pad_char();
    return ($urandom_range(0, 1) == 0) ? CHAR_EQ : CHAR_DOT;
  endfunction

  function automatic logic [7:0] line_break();
    return ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF;
  endfunction

  function automatic logic [7:0] any_byte();
    int v;
    v = $urandom_range(0, 255);
    return v[7:0];
  endfunction

  // one random stream: mostly well-formed, some cut short, some pure noise
  task automatic random_stream();
    int         kind;
    int         groups;
    int         npad;
    int         len;
    bit         crlf_end;
    logic [7:0] ch;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      groups = $urandom_range(1, 5);
      npad = $urandom_range(0, 2);
      crlf_end = ($urandom_range(0, 5) == 0);
      for (int g = 0; g < groups; g++) begin
        for (int p = 0; p < 4; p++) begin
          ch = valid_char();
          if (g == groups - 1 && p >= 4 - npad && !crlf_end) ch = pad_char();
          else if ($urandom_range(0, 24) == 0) ch = pad_char();
          else if ($urandom_range(0, 39) == 0) ch = any_byte();
          if ($urandom_range(0, 9) == 0) send(line_break(), 1'b0, 1'b0, 0, '0);
          send(ch, !crlf_end && g == groups - 1 && p == 3, 1'b0, 0, '0);
        end
      end
      if (crlf_end) send(line_break(), 1'b1, 1'b0, 0, '0);
    end else if (kind < 17) begin
      // truncated or overlong stream of valid characters
      len = $urandom_range(1, 11);
      for (int i = 0; i < len; i++) send(valid_char(), i == len - 1, 1'b0, 0, '0);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send(any_byte(), $urandom_range(0, 7) == 0, 1'b0, 0, '0);
    end
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_char         <= 8'h00;
    in_end_of_input <= 1'b0;
    cur_typed       <= 1'b0;
    cur_n           <= 0;
    cur_res         <= '0;
    errors         = 0;
    sent_items     = 0;
    accepted_items = 0;
    quiet_cycles   = 0;
    drain_phase    = 1'b0;
    clear_stream();

    // empty stream closed by a carriage return right after reset
    add_row(CHAR_CR, 1'b1, 1'b1, 1, {NO_RESULT, NO_RESULT, MARK_OK});
    // all-ones group closing the stream
    add_row("/", 1'b0, 1'b0, 0, '0);
    add_row("/", 1'b0, 1'b0, 0, '0);
    add_row("/", 1'b0, 1'b0, 0, '0);
    add_row("/", 1'b1, 1'b1, 3, {BYTE_FF_LAST, BYTE_FF, BYTE_FF});
    // url-safe characters, both pad kinds in the final group
    add_row("-", 1'b0, 1'b0, 0, '0);
    add_row("_", 1'b0, 1'b0, 0, '0);
    add_row(CHAR_EQ, 1'b0, 1'b0, 0, '0);
    add_row(CHAR_DOT, 1'b1, 1'b0, 0, '0);
    // bad character, pads in a group that is not final, skipped line feed,
    // then the stream ends on a carriage return after a complete group
    add_row(8'hFF, 1'b0, 1'b0, 0, '0);
    add_row("A", 1'b0, 1'b0, 0, '0);
    add_row(CHAR_EQ, 1'b0, 1'b0, 0, '0);
    add_row(CHAR_DOT, 1'b0, 1'b0, 0, '0);
    add_row(CHAR_LF, 1'b0, 1'b0, 0, '0);
    add_row(CHAR_CR, 1'b1, 1'b0, 0, '0);
    // pad in first place, high-bit characters, final group ends without pads
    add_row(CHAR_EQ, 1'b0, 1'b0, 0, '0);
    add_row(8'h80, 1'b0, 1'b0, 0, '0);
    add_row(8'hBD, 1'b0, 1'b0, 0, '0);
    add_row("+", 1'b1, 1'b0, 0, '0);
    // stream that stops after two characters
    add_row("z", 1'b0, 1'b0, 0, '0);
    add_row("9", 1'b1, 1'b1, 1, {NO_RESULT, NO_RESULT, MARK_ERR});
    // empty stream closed by a line feed
    add_row(CHAR_LF, 1'b1, 1'b1, 1, {NO_RESULT, NO_RESULT, MARK_OK});
    // one pad in the last place drops one byte
    add_row("Z", 1'b0, 1'b0, 0, '0);
    add_row("m", 1'b0, 1'b0, 0, '0);
    add_row("9", 1'b0, 1'b0, 0, '0);
    add_row(CHAR_EQ, 1'b1, 1'b0, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k])
      send(stim_rows[k].ch, stim_rows[k].eoi, stim_rows[k].typed,
           stim_rows[k].n, stim_rows[k].res);

    while (sent_items < ITEM_TOTAL) begin
      if (sent_items >= DRAIN_FROM) drain_phase = 1'b1;
      random_stream();
    end
    drain_phase = 1'b1;
    in_valid <= 1'b0;

    // let the queue empty, then watch for stray results
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("** base64_stream_decoder: PASSED **");
    end else begin
      $display("** base64_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== base64_stream_decoder.f =====
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_fifo.sv
rtl/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
